[hdl/afe_pkg.sv]
// Shared types and constants for the API frame encoder.
package afe_pkg;

   localparam int QUEUE_DEPTH_DEF = 4;
   localparam int CSR_INDEX_W     = 8;

   localparam logic [7:0] ESC_XOR  = 8'h20;
   localparam logic [7:0] SUM_BASE = 8'hFF;

   localparam logic [CSR_INDEX_W-1:0] REG_START  = CSR_INDEX_W'(0);
   localparam logic [CSR_INDEX_W-1:0] REG_ESCAPE = CSR_INDEX_W'(1);
   localparam logic [CSR_INDEX_W-1:0] REG_XON    = CSR_INDEX_W'(2);
   localparam logic [CSR_INDEX_W-1:0] REG_XOFF   = CSR_INDEX_W'(3);

   localparam logic [7:0] START_RST  = 8'h7E;
   localparam logic [7:0] ESCAPE_RST = 8'h7D;
   localparam logic [7:0] XON_RST    = 8'h11;
   localparam logic [7:0] XOFF_RST   = 8'h13;

   typedef struct packed {
      logic [7:0] start_value;
      logic [7:0] escape_value;
      logic [7:0] xon_value;
      logic [7:0] xoff_value;
   } cfg_type;

   typedef struct packed {
      logic        hdr;
      logic [15:0] len;
      logic [7:0]  data;
      logic        csum_en;
      logic [7:0]  csum;
   } job_type;

   typedef enum logic [2:0] {
      PH_START,
      PH_LEN_HI,
      PH_LEN_LO,
      PH_DATA,
      PH_CSUM
   } phase_type;

endpackage

[hdl/afe_front.sv]
// Front end: frame tracking, length count and checksum, builds one job per in-frame byte.
module afe_front (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   input  logic [23:0]      req_tdata,   // data_byte[7:0], frame_length[23:8]
   input  logic             req_tuser,   // first_of_frame
   output logic             push,
   output afe_pkg::job_type push_data,
   input  logic             full
);
   import afe_pkg::*;

   logic        in_frame_ff, in_frame_in;
   logic [15:0] left_ff, left_in;
   logic [7:0]  sum_ff, sum_in;

   logic        xfer;
   logic [7:0]  data;
   logic [15:0] len;
   logic [15:0] left_cur;
   logic [15:0] left_new;
   logic [7:0]  sum_new;
   logic        done;

   assign req_tready = !full;
   assign xfer       = req_tvalid && req_tready;
   assign data       = req_tdata[7:0];
   assign len        = req_tdata[23:8];

   always_comb begin
      if (req_tuser) begin
         left_cur = (len == 16'd0) ? 16'd1 : len;
         sum_new  = data;
      end else begin
         left_cur = left_ff;
         sum_new  = sum_ff + data;
      end
      left_new = left_cur - 16'd1;
      done     = (left_new == 16'd0);

      push              = xfer && (req_tuser || in_frame_ff);
      push_data.hdr     = req_tuser;
      push_data.len     = len;
      push_data.data    = data;
      push_data.csum_en = done;
      push_data.csum    = SUM_BASE - sum_new;

      in_frame_in = in_frame_ff;
      left_in     = left_ff;
      sum_in      = sum_ff;
      if (push) begin
         in_frame_in = !done;
         left_in     = left_new;
         sum_in      = done ? 8'd0 : sum_new;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_frame_ff <= 1'b0;
         left_ff     <= 16'd0;
         sum_ff      <= 8'd0;
      end else begin
         in_frame_ff <= in_frame_in;
         left_ff     <= left_in;
         sum_ff      <= sum_in;
      end
   end

endmodule

[hdl/afe_fifo.sv]
// Small job queue between front and back end.
module afe_fifo #(
   parameter int DEPTH = afe_pkg::QUEUE_DEPTH_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  afe_pkg::job_type push_data,
   output logic             full,
   input  logic             pop,
   output afe_pkg::job_type pop_data,
   output logic             empty
);
   import afe_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   job_type            mem_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;

   assign full     = (count_ff == CNT_W'(DEPTH));
   assign empty    = (count_ff == '0);
   assign pop_data = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (push)
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      if (pop)
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      count_in = count_ff + CNT_W'(push) - CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push)
         mem_ff[wr_ptr_ff] <= push_data;
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> (!full || pop))
      else $error("queue push while full");
   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> !empty)
      else $error("queue pop while empty");
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("queue count out of range");

endmodule

[hdl/afe_back.sv]
// Back end: walks each job byte by byte, escapes, drives the output register.
module afe_back (
   input  logic             clock,
   input  logic             reset,
   input  afe_pkg::cfg_type cfg,
   input  logic             empty,
   input  afe_pkg::job_type pop_data,
   output logic             pop,
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   output logic [7:0]       rsp_tdata,   // out_byte
   output logic             rsp_tlast,   // last_in_run
   output logic             rsp_tuser    // frame_done
);
   import afe_pkg::*;

   job_type   job_ff, job_in;
   logic      job_vld_ff, job_vld_in;
   phase_type phase_ff, phase_in;
   logic      esc_ff, esc_in;

   logic       out_vld_ff, out_vld_in;
   logic [7:0] out_byte_ff, out_byte_in;
   logic       out_last_ff, out_last_in;
   logic       out_done_ff, out_done_in;

   logic       emit_ok;
   logic       fire;
   logic [7:0] raw_byte;
   logic       needs_esc;
   logic       step_done;
   logic       job_end;
   logic [7:0] emit_byte;
   logic       load;

   assign emit_ok = !out_vld_ff || rsp_tready;
   assign fire    = job_vld_ff && emit_ok;

   // output decode for the current phase
   always_comb begin
      case (phase_ff)
         PH_START:  raw_byte = cfg.start_value;
         PH_LEN_HI: raw_byte = job_ff.len[15:8];
         PH_LEN_LO: raw_byte = job_ff.len[7:0];
         PH_DATA:   raw_byte = job_ff.data;
         PH_CSUM:   raw_byte = job_ff.csum;
         default:   raw_byte = job_ff.data;
      endcase
      needs_esc = (phase_ff != PH_START) &&
                  ((raw_byte == cfg.start_value) || (raw_byte == cfg.escape_value) ||
                   (raw_byte == cfg.xon_value)   || (raw_byte == cfg.xoff_value));
      step_done = esc_ff || !needs_esc;
      if (esc_ff)
         emit_byte = raw_byte ^ ESC_XOR;
      else if (needs_esc)
         emit_byte = cfg.escape_value;
      else
         emit_byte = raw_byte;
      job_end = step_done &&
                (((phase_ff == PH_DATA) && !job_ff.csum_en) || (phase_ff == PH_CSUM));
      load = (!job_vld_ff || (fire && job_end)) && !empty;
      pop  = load;
   end

   // next state
   always_comb begin
      phase_in   = phase_ff;
      esc_in     = esc_ff;
      job_in     = job_ff;
      job_vld_in = job_vld_ff;
      if (fire) begin
         esc_in = !step_done;
         if (step_done) begin
            case (phase_ff)
               PH_START:  phase_in = PH_LEN_HI;
               PH_LEN_HI: phase_in = PH_LEN_LO;
               PH_LEN_LO: phase_in = PH_DATA;
               PH_DATA:   phase_in = PH_CSUM;
               PH_CSUM:   phase_in = PH_START;
               default:   phase_in = PH_DATA;
            endcase
         end
         if (job_end)
            job_vld_in = 1'b0;
      end
      if (load) begin
         job_in     = pop_data;
         job_vld_in = 1'b1;
         phase_in   = pop_data.hdr ? PH_START : PH_DATA;
         esc_in     = 1'b0;
      end
   end

   // output register
   always_comb begin
      out_vld_in  = out_vld_ff;
      out_byte_in = out_byte_ff;
      out_last_in = out_last_ff;
      out_done_in = out_done_ff;
      if (fire) begin
         out_vld_in  = 1'b1;
         out_byte_in = emit_byte;
         out_last_in = job_end;
         out_done_in = job_end && (phase_ff == PH_CSUM);
      end else if (rsp_tready) begin
         out_vld_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         job_vld_ff <= 1'b0;
         phase_ff   <= PH_START;
         esc_ff     <= 1'b0;
         out_vld_ff <= 1'b0;
      end else begin
         job_vld_ff <= job_vld_in;
         phase_ff   <= phase_in;
         esc_ff     <= esc_in;
         out_vld_ff <= out_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      job_ff      <= job_in;
      out_byte_ff <= out_byte_in;
      out_last_ff <= out_last_in;
      out_done_ff <= out_done_in;
   end

   assign rsp_tvalid = out_vld_ff;
   assign rsp_tdata  = out_byte_ff;
   assign rsp_tlast  = out_last_ff;
   assign rsp_tuser  = out_done_ff;

   a_done_is_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser) |-> rsp_tlast)
      else $error("frame end without run end");
   a_esc_has_job: assert property (@(posedge clock) disable iff (reset)
      esc_ff |-> job_vld_ff)
      else $error("escape pending without job");
   a_start_has_hdr: assert property (@(posedge clock) disable iff (reset)
      (job_vld_ff && (phase_ff == PH_START)) |-> job_ff.hdr)
      else $error("header phase on a non-header job");
   a_csum_enabled: assert property (@(posedge clock) disable iff (reset)
      (job_vld_ff && (phase_ff == PH_CSUM)) |-> job_ff.csum_en)
      else $error("checksum phase without checksum");

endmodule

[hdl/api_frame_encoder.sv]
// Top level: escaped API frame encoder with checksum.
// The first line byte of an item passes the job queue, the job register and the output register.
// Throughput: one line byte per cycle while rsp_tready is not held low; a job yields 1 to 9 line
// bytes (1 for an unescaped payload byte, up to 9 for a frame's first and last byte).
// The QUEUE_DEPTH-entry job queue decouples input transfers from the byte emitter.
// Reset (synchronous, active high) closes any frame, empties the queue, restores registers.
module api_frame_encoder #(
   parameter int QUEUE_DEPTH = afe_pkg::QUEUE_DEPTH_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [23:0]                     req_tdata,   // data_byte[7:0], frame_length[23:8]
   input  logic                            req_tuser,   // first_of_frame
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [7:0]                      rsp_tdata,   // out_byte
   output logic                            rsp_tlast,   // last_in_run
   output logic                            rsp_tuser,   // frame_done
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [afe_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [7:0]                      csr_data
);
   import afe_pkg::*;

   cfg_type cfg_ff, cfg_in;
   logic    push;
   job_type push_data;
   logic    full;
   logic    pop;
   job_type pop_data;
   logic    empty;

   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            REG_START:  cfg_in.start_value  = csr_data;
            REG_ESCAPE: cfg_in.escape_value = csr_data;
            REG_XON:    cfg_in.xon_value    = csr_data;
            REG_XOFF:   cfg_in.xoff_value   = csr_data;
            default:    cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.start_value  <= START_RST;
         cfg_ff.escape_value <= ESCAPE_RST;
         cfg_ff.xon_value    <= XON_RST;
         cfg_ff.xoff_value   <= XOFF_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   afe_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .push       (push),
      .push_data  (push_data),
      .full       (full)
   );

   afe_fifo #(
      .DEPTH (QUEUE_DEPTH)
   ) u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .full      (full),
      .pop       (pop),
      .pop_data  (pop_data),
      .empty     (empty)
   );

   afe_back u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .empty      (empty),
      .pop_data   (pop_data),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

[bench/api_frame_encoder_tb.sv]
// Self-checking bench for api_frame_encoder: directed and random frames checked per line byte.
`timescale 1ns / 100ps

module api_frame_encoder_tb;
   import afe_pkg::*;

   localparam int CYCLE_LIMIT     = 400000;
   localparam int SETTLE_CYCLES   = 20;
   localparam int HOLD_CYCLES     = 400;
   localparam int IDLE_PCT        = 27;
   localparam int ITEMS_PER_PHASE = 62;
   localparam logic [CSR_INDEX_W-1:0] REG_NONE = CSR_INDEX_W'(8'hC4);

   typedef struct packed {
      logic        drain;
      logic [15:0] len;
      logic        first;
      logic [7:0]  data;
   } frame_item_type;

   typedef struct packed {
      logic       done;
      logic       last;
      logic [7:0] octet;
   } line_octet_type;

   logic                   clock      = 1'b0;
   logic                   reset      = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [23:0]            req_tdata  = '0;   // data_byte[7:0], frame_length[23:8]
   logic                   req_tuser  = 1'b0; // first_of_frame
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [7:0]             rsp_tdata;         // out_byte
   logic                   rsp_tlast;         // last_in_run
   logic                   rsp_tuser;         // frame_done
   logic                   csr_valid  = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index  = '0;
   logic [7:0]             csr_data   = '0;

   // encoder state as predicted
   cfg_type        enc_cfg;
   logic           frame_open;
   logic [15:0]    bytes_left;
   logic [7:0]     payload_sum;
   line_octet_type run_buf [0:8];
   int             run_len;

   frame_item_type tx_items[$];
   line_octet_type line_octets_due[$];
   frame_item_type cur_item;
   line_octet_type want;

   int errors       = 0;
   int cycle_count  = 0;
   int hold_trigger = 0;
   int hold_seen    = 0;
   int hold_left    = 0;
   bit calm         = 1'b0;

   api_frame_encoder uut (
      .clock, .reset,
      .req_tvalid, .req_tready, .req_tdata, .req_tuser,
      .rsp_tvalid, .rsp_tready, .rsp_tdata, .rsp_tlast, .rsp_tuser,
      .csr_valid, .csr_ready, .csr_index, .csr_data
   );

   initial begin
      forever #6 clock = ~clock;
   end

   function automatic void emit(input logic [7:0] b);
      run_buf[run_len] = {1'b0, 1'b0, b};
      run_len++;
   endfunction

   function automatic void emit_escaped(input logic [7:0] b);
      if (b == enc_cfg.start_value || b == enc_cfg.escape_value ||
          b == enc_cfg.xon_value || b == enc_cfg.xoff_value) begin
         emit(enc_cfg.escape_value);
         emit(b ^ ESC_XOR);
      end else begin
         emit(b);
      end
   endfunction

   function automatic void encode_item(input frame_item_type it);
      run_len = 0;
      if (it.first) begin
         emit(enc_cfg.start_value);
         emit_escaped(it.len[15:8]);
         emit_escaped(it.len[7:0]);
         frame_open  = 1'b1;
         payload_sum = '0;
         bytes_left  = (it.len == 16'd0) ? 16'd1 : it.len;
      end
      if (frame_open) begin
         emit_escaped(it.data);
         payload_sum = payload_sum + it.data;
         bytes_left  = bytes_left - 16'd1;
         if (bytes_left == 16'd0) begin
            emit_escaped(SUM_BASE - payload_sum);
            run_buf[run_len-1].done = 1'b1;
            frame_open  = 1'b0;
            payload_sum = '0;
         end
         run_buf[run_len-1].last = 1'b1;
         for (int i = 0; i < run_len; i++) line_octets_due.push_back(run_buf[i]);
      end
   endfunction

   // biased toward the escaped values
   function automatic logic [7:0] pick_octet();
      case ($urandom_range(7))
         0: return enc_cfg.start_value;
         1: return enc_cfg.escape_value;
         2: return enc_cfg.xon_value;
         3: return enc_cfg.xoff_value;
         default: return 8'($urandom);
      endcase
   endfunction

   task automatic queue_item(input logic [7:0] data, input logic first,
                             input logic [15:0] len, input logic drain);
      frame_item_type it;
      it.data  = data;
      it.first = first;
      it.len   = len;
      it.drain = drain;
      tx_items.push_back(it);
   endtask

   task automatic queue_frame(output int used);
      int          kind;
      int          count;
      logic [15:0] len;
      logic [15:0] span;
      kind = $urandom_range(99);
      if (kind < 70) len = 16'($urandom_range(1, 8));
      else if (kind < 78) len = 16'd0;
      else if (kind < 90) len = {pick_octet(), pick_octet()};
      else len = 16'($urandom);
      span  = (len == 16'd0) ? 16'd1 : len;
      count = (kind < 78) ? int'(span) : $urandom_range(1, 4);
      if (count > int'(span)) count = int'(span);
      queue_item(pick_octet(), 1'b1, len, $urandom_range(49) == 0);
      for (int i = 1; i < count; i++) queue_item(pick_octet(), 1'b0, 16'($urandom), 1'b0);
      // stray bytes after a closed frame get dropped
      if (count == int'(span) && $urandom_range(7) == 0)
         repeat ($urandom_range(1, 2)) queue_item(8'($urandom), 1'b0, 16'($urandom), 1'b0);
      used = count;
   endtask

   task automatic run_random(input int target);
      int queued;
      int used;
      queued = 0;
      while (queued < target) begin
         queue_frame(used);
         queued += used;
      end
   endtask

   task automatic settle();
      while (tx_items.size() != 0 || req_tvalid || line_octets_due.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_INDEX_W-1:0] idx, input logic [7:0] val);
      csr_index <= idx;
      csr_data  <= val;
      csr_valid <= 1'b1;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      case (idx)
         REG_START:  enc_cfg.start_value  = val;
         REG_ESCAPE: enc_cfg.escape_value = val;
         REG_XON:    enc_cfg.xon_value    = val;
         REG_XOFF:   enc_cfg.xoff_value   = val;
         default: ;
      endcase
      @(posedge clock);
   endtask

   task automatic set_regs(input logic [7:0] s, input logic [7:0] e,
                           input logic [7:0] xn, input logic [7:0] xf);
      settle();
      write_csr(REG_START, s);
      write_csr(REG_ESCAPE, e);
      write_csr(REG_XON, xn);
      write_csr(REG_XOFF, xf);
   endtask

   // sender
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) encode_item(cur_item);
         if (!req_tvalid || req_tready) begin
            if (tx_items.size() > 0 && (calm || $urandom_range(99) >= IDLE_PCT) &&
                !(tx_items[0].drain && line_octets_due.size() != 0)) begin
               cur_item = tx_items.pop_front();
               req_tdata  <= {cur_item.len, cur_item.data};
               req_tuser  <= cur_item.first;
               req_tvalid <= 1'b1;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // receiver and checker
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (line_octets_due.size() == 0) begin
               $error("unexpected transfer: out_byte %h", rsp_tdata);
               errors++;
            end else begin
               want = line_octets_due.pop_front();
               if (rsp_tdata !== want.octet) begin
                  $error("out_byte: expected %h, actual %h", want.octet, rsp_tdata);
                  errors++;
               end
               if (rsp_tlast !== want.last) begin
                  $error("last_in_run: expected %b, actual %b", want.last, rsp_tlast);
                  errors++;
               end
               if (rsp_tuser !== want.done) begin
                  $error("frame_done: expected %b, actual %b", want.done, rsp_tuser);
                  errors++;
               end
            end
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else if (hold_trigger != hold_seen) begin
            hold_seen = hold_trigger;
            hold_left = HOLD_CYCLES;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= calm || ($urandom_range(99) >= IDLE_PCT);
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   initial begin
      enc_cfg     = {START_RST, ESCAPE_RST, XON_RST, XOFF_RST};
      frame_open  = 1'b0;
      bytes_left  = '0;
      payload_sum = '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // reset register values
      queue_item(8'hFF, 1'b0, 16'hFFFF, 1'b0);   // outside a frame
      queue_item(8'h00, 1'b1, 16'h0001, 1'b0);
      queue_item(8'h7E, 1'b1, 16'h0000, 1'b0);   // zero length
      queue_item(8'h11, 1'b1, 16'h7E7D, 1'b0);   // escaped length bytes
      queue_item(8'h13, 1'b0, 16'h0000, 1'b0);
      queue_item(8'h7D, 1'b0, 16'h0000, 1'b0);
      queue_item(8'h7E, 1'b0, 16'h0000, 1'b0);
      queue_item(8'hFF, 1'b0, 16'h0000, 1'b0);
      queue_item(8'h00, 1'b0, 16'h0000, 1'b0);
      queue_item(8'hAA, 1'b1, 16'hFFFF, 1'b0);   // abandons open frame
      queue_item(8'h55, 1'b0, 16'h0000, 1'b0);
      queue_item(8'h80, 1'b1, 16'h0003, 1'b0);   // abandons again
      queue_item(8'h01, 1'b0, 16'h0000, 1'b0);
      queue_item(8'h00, 1'b0, 16'h0000, 1'b0);   // checksum 7E, escaped
      queue_item(8'h7E, 1'b0, 16'h0000, 1'b0);   // dropped
      queue_item(8'h7D, 1'b1, 16'h1113, 1'b0);
      queue_item(8'h13, 1'b0, 16'hAAAA, 1'b0);
      queue_item(8'hFF, 1'b1, 16'h0002, 1'b0);
      queue_item(8'h01, 1'b0, 16'h5555, 1'b0);
      queue_item(8'hFF, 1'b1, 16'h0001, 1'b0);

      set_regs(8'h00, 8'h00, 8'h00, 8'h00);
      queue_item(8'h00, 1'b1, 16'h0000, 1'b0);
      run_random(ITEMS_PER_PHASE);

      set_regs(8'hFF, 8'hFF, 8'hFF, 8'hFF);
      run_random(ITEMS_PER_PHASE);

      // every byte after the start value of a one-byte frame escaped
      set_regs(8'h00, 8'h01, 8'h80, 8'h7F);
      queue_item(8'h80, 1'b1, 16'h0001, 1'b0);
      queue_item(8'h7F, 1'b1, 16'h0000, 1'b0);
      run_random(ITEMS_PER_PHASE);

      set_regs(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
      hold_trigger++;
      run_random(ITEMS_PER_PHASE);
      queue_item(8'h3C, 1'b1, 16'h0002, 1'b1);
      queue_item(8'hC3, 1'b0, 16'h0000, 1'b0);

      set_regs(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
      write_csr(REG_NONE, 8'h7E);
      calm = 1'b1;
      run_random(ITEMS_PER_PHASE);
      settle();
      calm = 1'b0;

      set_regs(START_RST, ESCAPE_RST, XON_RST, XOFF_RST);
      run_random(ITEMS_PER_PHASE);
      settle();

      if (errors == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
